>>> hdl/qrrts_pkg.sv
package qrrts_pkg;

	localparam int NUM_CPUS     = 4;
	localparam int MAX_TASKS    = 16;
	localparam int TASK_ID_BITS = 16;

	localparam int CPU_BITS  = $clog2(NUM_CPUS);
	localparam int SLOT_BITS = $clog2(MAX_TASKS);
	localparam int LEN_BITS  = SLOT_BITS + 1;
	localparam int ADDR_BITS = CPU_BITS + SLOT_BITS;
	localparam int DEPTH     = NUM_CPUS * MAX_TASKS;

	localparam int FUNC_BITS   = 2;
	localparam int STATUS_BITS = 2;
	localparam int QUANT_BITS  = 16;
	localparam int ACT_BITS    = 3;
	localparam int TICK_BITS   = 16;
	localparam int CPU_W       = 2;
	localparam int SLOT_W      = 4;
	localparam int TASK_W      = 16;

	localparam logic [TICK_BITS-1:0]  TICK_MAX      = '1;
	localparam logic [QUANT_BITS-1:0] QUANTUM_RESET = 16'd20;
	localparam logic [ACT_BITS-1:0]   ACT_RESET     = 3'd4;
	localparam logic                  MARK_READY    = 1'b1;

	localparam logic REG_QUANTUM = 1'b0;
	localparam logic REG_ACTIVE  = 1'b1;

	typedef enum logic [FUNC_BITS-1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_PUSH  = 2'd1,
		FUNC_READY = 2'd2
	} func_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_NO_READY = 2'd2
	} status_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load_out;
	} ctrl_cmd_t;

endpackage

>>> hdl/qrrts_if.sv
interface qrrts_in_if;
	logic                                valid;
	logic                                ready;
	logic [qrrts_pkg::FUNC_BITS-1:0]     func;
	logic [qrrts_pkg::CPU_W-1:0]         cpu_index;
	logic [qrrts_pkg::SLOT_W-1:0]        slot_index;
	logic [qrrts_pkg::TASK_W-1:0]        task_id;
	logic                                ready_in;

	modport source (output valid, func, cpu_index, slot_index, task_id, ready_in, input ready);
	modport sink (input valid, func, cpu_index, slot_index, task_id, ready_in, output ready);
endinterface

interface qrrts_out_if;
	logic                                valid;
	logic                                ready;
	logic                                switched;
	logic [qrrts_pkg::CPU_W-1:0]         cpu_out;
	logic [qrrts_pkg::SLOT_W-1:0]        slot_out;
	logic [qrrts_pkg::TASK_W-1:0]        task_out;
	logic [qrrts_pkg::STATUS_BITS-1:0]   status;

	modport source (output valid, switched, cpu_out, slot_out, task_out, status, input ready);
	modport sink (input valid, switched, cpu_out, slot_out, task_out, status, output ready);
endinterface

>>> hdl/qrrts_ctrl.sv
module qrrts_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  rsp_ready,
	output logic                  req_ready,
	output logic                  rsp_valid,
	output qrrts_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free     = !out_valid_q || rsp_ready;
	assign req_ready    = (state_q == ST_IDLE) || ((state_q == ST_FIN) && out_free);
	assign cmd.capture  = req_valid && req_ready;
	assign cmd.exec     = (state_q == ST_EXEC);
	assign cmd.load_out = (state_q == ST_FIN) && out_free;
	assign rsp_valid    = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.capture) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) state_d = cmd.capture ? ST_EXEC : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

>>> hdl/qrrts_dp.sv
module qrrts_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  qrrts_pkg::ctrl_cmd_t                 cmd,
	input  logic [qrrts_pkg::FUNC_BITS-1:0]      func,
	input  logic [qrrts_pkg::CPU_W-1:0]          cpu_index,
	input  logic [qrrts_pkg::SLOT_W-1:0]         slot_index,
	input  logic [qrrts_pkg::TASK_W-1:0]         task_id,
	input  logic                                 ready_in,
	input  logic [qrrts_pkg::QUANT_BITS-1:0]     quantum,
	input  logic [qrrts_pkg::ACT_BITS-1:0]       active_cpus,
	output logic                                 switched,
	output logic [qrrts_pkg::CPU_W-1:0]          cpu_out,
	output logic [qrrts_pkg::SLOT_W-1:0]         slot_out,
	output logic [qrrts_pkg::TASK_W-1:0]         task_out,
	output logic [qrrts_pkg::STATUS_BITS-1:0]    status
);

	// captured item
	logic [qrrts_pkg::FUNC_BITS-1:0]    func_q;
	logic [qrrts_pkg::CPU_BITS-1:0]     cpu_q;
	logic [qrrts_pkg::SLOT_BITS-1:0]    slot_q;
	logic [qrrts_pkg::TASK_ID_BITS-1:0] tid_q;
	logic                               rdy_q;

	// run list state
	logic [qrrts_pkg::MAX_TASKS-1:0]    ready_q [qrrts_pkg::NUM_CPUS];
	logic [qrrts_pkg::LEN_BITS-1:0]     len_q   [qrrts_pkg::NUM_CPUS];
	logic [qrrts_pkg::SLOT_BITS-1:0]    cur_q   [qrrts_pkg::NUM_CPUS];
	logic [qrrts_pkg::TICK_BITS-1:0]    cnt_q   [qrrts_pkg::NUM_CPUS];

	logic [qrrts_pkg::TASK_ID_BITS-1:0] mem [qrrts_pkg::DEPTH];
	logic [qrrts_pkg::TASK_ID_BITS-1:0] rd_q;

	// execute stage results
	logic                               sw_s1;
	logic [qrrts_pkg::CPU_BITS-1:0]     cpu_s1;
	logic [qrrts_pkg::SLOT_BITS-1:0]    slot_s1;
	logic [qrrts_pkg::TASK_ID_BITS-1:0] task_s1;
	logic [qrrts_pkg::STATUS_BITS-1:0]  st_s1;
	logic                               mem_task_s1;
	logic                               slot_zero_s1;

	// output register
	logic                               sw_q;
	logic [qrrts_pkg::CPU_BITS-1:0]     cpu_out_q;
	logic [qrrts_pkg::SLOT_BITS-1:0]    slot_out_q;
	logic [qrrts_pkg::TASK_ID_BITS-1:0] task_out_q;
	logic [qrrts_pkg::STATUS_BITS-1:0]  st_q;

	logic [qrrts_pkg::ACT_BITS-1:0]     act;
	logic                               cpu_ok;
	logic [qrrts_pkg::LEN_BITS-1:0]     len_c;
	logic [qrrts_pkg::SLOT_BITS-1:0]    cur_c;
	logic [qrrts_pkg::TICK_BITS-1:0]    old_cnt;
	logic                               switch_due;
	logic [qrrts_pkg::MAX_TASKS-1:0]    row;
	logic                               found;
	logic [qrrts_pkg::SLOT_BITS-1:0]    found_idx;
	logic [qrrts_pkg::SLOT_BITS-1:0]    tick_cur;
	logic [qrrts_pkg::CPU_BITS-1:0]     best;
	logic [qrrts_pkg::LEN_BITS-1:0]     len_best;
	logic                               full;
	logic                               slot_ok;

	logic                               res_sw;
	logic [qrrts_pkg::CPU_BITS-1:0]     res_cpu;
	logic [qrrts_pkg::SLOT_BITS-1:0]    res_slot;
	logic [qrrts_pkg::TASK_ID_BITS-1:0] res_task;
	logic [qrrts_pkg::STATUS_BITS-1:0]  res_st;
	logic                               res_mem;
	logic [qrrts_pkg::SLOT_BITS-1:0]    mem_slot;
	logic                               mem_we;
	logic [qrrts_pkg::TASK_ID_BITS-1:0] task_sel;

	always_comb begin
		if (active_cpus == '0) act = qrrts_pkg::ACT_BITS'(1);
		else if (active_cpus > qrrts_pkg::ACT_BITS'(qrrts_pkg::NUM_CPUS))
			act = qrrts_pkg::ACT_BITS'(qrrts_pkg::NUM_CPUS);
		else act = active_cpus;
	end

	assign cpu_ok     = qrrts_pkg::ACT_BITS'(cpu_q) < act;
	assign len_c      = len_q[cpu_q];
	assign cur_c      = (qrrts_pkg::LEN_BITS'(cur_q[cpu_q]) >= len_c) ? '0 : cur_q[cpu_q];
	assign old_cnt    = cnt_q[cpu_q];
	assign switch_due = (old_cnt > qrrts_pkg::TICK_BITS'(quantum)) &&
		(len_c > qrrts_pkg::LEN_BITS'(1));
	assign row        = ready_q[cpu_q];

	// next ready slot after the current one, wrapping within the list
	always_comb begin
		logic [qrrts_pkg::MAX_TASKS-1:0] hi;
		logic [qrrts_pkg::MAX_TASKS-1:0] lo;
		logic                            hi_found;
		logic [qrrts_pkg::SLOT_BITS-1:0] hi_idx;
		logic                            lo_found;
		logic [qrrts_pkg::SLOT_BITS-1:0] lo_idx;
		hi_found = 1'b0;
		hi_idx   = '0;
		lo_found = 1'b0;
		lo_idx   = '0;
		for (int i = 0; i < qrrts_pkg::MAX_TASKS; i++) begin
			hi[i] = row[i] && (qrrts_pkg::SLOT_BITS'(i) > cur_c) &&
				(qrrts_pkg::LEN_BITS'(i) < len_c);
			lo[i] = row[i] && (qrrts_pkg::SLOT_BITS'(i) <= cur_c);
		end
		for (int i = qrrts_pkg::MAX_TASKS - 1; i >= 0; i--) begin
			if (hi[i]) begin
				hi_found = 1'b1;
				hi_idx   = qrrts_pkg::SLOT_BITS'(i);
			end
			if (lo[i]) begin
				lo_found = 1'b1;
				lo_idx   = qrrts_pkg::SLOT_BITS'(i);
			end
		end
		found     = hi_found || lo_found;
		found_idx = hi_found ? hi_idx : lo_idx;
	end

	assign tick_cur = (switch_due && found) ? found_idx : cur_c;

	// least-loaded active processor, lowest index on a tie
	always_comb begin
		best = '0;
		for (int i = 1; i < qrrts_pkg::NUM_CPUS; i++) begin
			if ((qrrts_pkg::ACT_BITS'(i) < act) && (len_q[i] < len_q[best]))
				best = qrrts_pkg::CPU_BITS'(i);
		end
	end

	assign len_best = len_q[best];
	assign full     = len_best >= qrrts_pkg::LEN_BITS'(qrrts_pkg::MAX_TASKS);
	assign slot_ok  = qrrts_pkg::LEN_BITS'(slot_q) < len_c;

	always_comb begin
		res_sw   = 1'b0;
		res_cpu  = '0;
		res_slot = '0;
		res_task = '0;
		res_st   = qrrts_pkg::STATUS_OK;
		res_mem  = 1'b0;
		mem_slot = slot_q;
		mem_we   = 1'b0;
		unique case (func_q)
			qrrts_pkg::FUNC_TICK: begin
				res_cpu  = cpu_q;
				mem_slot = tick_cur;
				if (cpu_ok) begin
					res_sw   = switch_due && found;
					res_slot = tick_cur;
					res_mem  = 1'b1;
					if (switch_due && !found) res_st = qrrts_pkg::STATUS_NO_READY;
				end
			end
			qrrts_pkg::FUNC_PUSH: begin
				res_cpu  = best;
				res_task = tid_q;
				if (full) begin
					res_st = qrrts_pkg::STATUS_FULL;
				end else begin
					res_slot = len_best[qrrts_pkg::SLOT_BITS-1:0];
					mem_we   = 1'b1;
				end
			end
			qrrts_pkg::FUNC_READY: begin
				res_cpu = cpu_q;
				if (cpu_ok) begin
					res_slot = slot_q;
					res_mem  = slot_ok;
				end
			end
			default: begin
				res_cpu = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < qrrts_pkg::NUM_CPUS; c++) begin
				ready_q[c] <= qrrts_pkg::MAX_TASKS'(qrrts_pkg::MARK_READY);
				len_q[c]   <= qrrts_pkg::LEN_BITS'(1);
				cur_q[c]   <= '0;
				cnt_q[c]   <= '0;
			end
		end else if (cmd.exec) begin
			unique case (func_q)
				qrrts_pkg::FUNC_TICK: begin
					if (cpu_ok) begin
						if (switch_due) cnt_q[cpu_q] <= '0;
						else if (old_cnt < qrrts_pkg::TICK_MAX) cnt_q[cpu_q] <= old_cnt + 1'b1;
						cur_q[cpu_q] <= tick_cur;
					end
				end
				qrrts_pkg::FUNC_PUSH: begin
					if (!full) begin
						len_q[best] <= len_best + 1'b1;
						ready_q[best][len_best[qrrts_pkg::SLOT_BITS-1:0]] <= rdy_q;
					end
				end
				qrrts_pkg::FUNC_READY: begin
					if (cpu_ok && slot_ok) ready_q[cpu_q][slot_q] <= rdy_q;
				end
				default: begin
				end
			endcase
		end
	end

	// task ids; slot 0 is never written and reads as the boot task
	always_ff @(posedge clk) begin
		if (cmd.exec && mem_we) mem[{best, len_best[qrrts_pkg::SLOT_BITS-1:0]}] <= tid_q;
		if (cmd.exec) rd_q <= mem[{cpu_q, mem_slot}];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			cpu_q  <= qrrts_pkg::CPU_BITS'(cpu_index);
			slot_q <= qrrts_pkg::SLOT_BITS'(slot_index);
			tid_q  <= qrrts_pkg::TASK_ID_BITS'(task_id);
			rdy_q  <= ready_in;
		end
		if (cmd.exec) begin
			sw_s1        <= res_sw;
			cpu_s1       <= res_cpu;
			slot_s1      <= res_slot;
			task_s1      <= res_task;
			st_s1        <= res_st;
			mem_task_s1  <= res_mem;
			slot_zero_s1 <= (mem_slot == '0);
		end
		if (cmd.load_out) begin
			sw_q       <= sw_s1;
			cpu_out_q  <= cpu_s1;
			slot_out_q <= slot_s1;
			task_out_q <= task_sel;
			st_q       <= st_s1;
		end
	end

	assign task_sel = mem_task_s1 ? (slot_zero_s1 ? '0 : rd_q) : task_s1;

	assign switched = sw_q;
	assign cpu_out  = qrrts_pkg::CPU_W'(cpu_out_q);
	assign slot_out = qrrts_pkg::SLOT_W'(slot_out_q);
	assign task_out = qrrts_pkg::TASK_W'(task_out_q);
	assign status   = st_q;

endmodule

>>> hdl/quantum_round_robin_task_scheduler.sv
// Round-robin scheduler with a time quantum over four per-processor run lists of sixteen
// slots. Every item (tick, push, set-ready) gives exactly one result. An item is taken,
// executed against the list registers, and its result is loaded into the output register
// once that register is free, after the registered read of the task-id memory. A new item
// is taken while idle or as the last result is loaded, never during execute, as long
// as results are taken. The output register lets the next item in while a result waits.
// No clearing pass after reset: slot 0 of every list reads as boot task 0, and all other
// slots are written before they can be read. quantum is at byte address 0, active_cpus at
// 4. The user must write configuration only while the block is idle; it is unenforced.
module quantum_round_robin_task_scheduler (
	input  logic                 clk,
	input  logic                 arst_n,
	qrrts_in_if.sink             req,
	qrrts_out_if.source          rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic [qrrts_pkg::QUANT_BITS-1:0] quantum_q;
	logic [qrrts_pkg::ACT_BITS-1:0]   active_cpus_q;
	logic                             cfg_write;
	qrrts_pkg::ctrl_cmd_t             cmd;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q     <= qrrts_pkg::QUANTUM_RESET;
			active_cpus_q <= qrrts_pkg::ACT_RESET;
		end else if (cfg_write) begin
			unique case (paddr[2])
				qrrts_pkg::REG_QUANTUM: quantum_q <= pwdata[qrrts_pkg::QUANT_BITS-1:0];
				qrrts_pkg::REG_ACTIVE:  active_cpus_q <= pwdata[qrrts_pkg::ACT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			qrrts_pkg::REG_QUANTUM: prdata = 32'(quantum_q);
			qrrts_pkg::REG_ACTIVE:  prdata = 32'(active_cpus_q);
			default:                prdata = '0;
		endcase
	end

	qrrts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.rsp_ready (rsp.ready),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd)
	);

	qrrts_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.func        (req.func),
		.cpu_index   (req.cpu_index),
		.slot_index  (req.slot_index),
		.task_id     (req.task_id),
		.ready_in    (req.ready_in),
		.quantum     (quantum_q),
		.active_cpus (active_cpus_q),
		.switched    (rsp.switched),
		.cpu_out     (rsp.cpu_out),
		.slot_out    (rsp.slot_out),
		.task_out    (rsp.task_out),
		.status      (rsp.status)
	);

	// a transfer in is always followed by an execute cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> cmd.exec)
		else $error("accepted item not executed");

	// no result overwritten while still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp.valid || rsp.ready))
		else $error("output register overwritten");

	a_exec_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !req.ready)
		else $error("item taken during execute");

	a_exec_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> !cmd.exec)
		else $error("execute lasted more than one cycle");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import qrrts_pkg::*;

	localparam logic [FUNC_BITS-1:0] FUNC_UNUSED  = 2'd3;
	localparam logic [2:0]           ADDR_QUANTUM = {REG_QUANTUM, 2'b00};
	localparam logic [2:0]           ADDR_ACTIVE  = {REG_ACTIVE, 2'b00};
	localparam int                   QUIET_LIMIT  = 4000;
	localparam int                   RAND_PHASES  = 7;
	localparam int                   PHASE_ITEMS  = 76;

	typedef struct packed {
		logic [FUNC_BITS-1:0] func;
		logic [CPU_W-1:0]     cpu;
		logic [SLOT_W-1:0]    slot;
		logic [TASK_W-1:0]    tid;
		logic                 rdy;
	} sched_item_t;

	typedef struct packed {
		logic                   switched;
		logic [CPU_W-1:0]       cpu;
		logic [SLOT_W-1:0]      slot;
		logic [TASK_W-1:0]      tid;
		logic [STATUS_BITS-1:0] status;
	} sched_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	qrrts_in_if  req_if ();
	qrrts_out_if rsp_if ();

	quantum_round_robin_task_scheduler dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// scheduler state as the testbench tracks it
	logic [TASK_W-1:0]    list_tid   [NUM_CPUS][MAX_TASKS];
	logic                 list_ready [NUM_CPUS][MAX_TASKS];
	logic [LEN_BITS-1:0]  run_len    [NUM_CPUS];
	logic [SLOT_W-1:0]    cur_slot   [NUM_CPUS];
	logic [TICK_BITS-1:0] tick_cnt   [NUM_CPUS];
	logic [QUANT_BITS-1:0] cfg_quantum;
	logic [ACT_BITS-1:0]   cfg_active;

	sched_item_t   queued_items [$];
	sched_result_t expected_results [$];
	int            fail_count;
	int            stall_pct;
	int            quiet_cycles;

	always #1 clk = ~clk;

	function automatic bit take_break();
		return $urandom_range(99) < stall_pct;
	endfunction

	function automatic sched_result_t schedule_item(sched_item_t it);
		sched_result_t r;
		logic [TICK_BITS-1:0] old_count;
		int act;
		int len;
		int cur;
		int best;
		int s;
		bit found;
		r = '0;
		found = 1'b0;
		act = (cfg_active < 1) ? 1 : (cfg_active > NUM_CPUS) ? NUM_CPUS : int'(cfg_active);
		r.cpu = it.cpu;
		case (it.func)
			FUNC_TICK: begin
				if (it.cpu < act) begin
					old_count = tick_cnt[it.cpu];
					if (old_count != TICK_MAX)
						tick_cnt[it.cpu] = old_count + 1'b1;
					len = run_len[it.cpu];
					cur = cur_slot[it.cpu];
					if (cur >= len)
						cur = 0;
					if (old_count > cfg_quantum && len > 1) begin
						tick_cnt[it.cpu] = '0;
						r.status = STATUS_NO_READY;
						for (int i = 1; i <= len; i++) begin
							s = (cur + i) % len;
							if (!found && list_ready[it.cpu][s]) begin
								found = 1'b1;
								best = s;
							end
						end
						if (found) begin
							cur = best;
							r.switched = 1'b1;
							r.status = STATUS_OK;
						end
					end
					cur_slot[it.cpu] = SLOT_W'(cur);
					r.slot = SLOT_W'(cur);
					r.tid = list_tid[it.cpu][cur];
				end
			end
			FUNC_PUSH: begin
				best = 0;
				for (int i = 1; i < act; i++)
					if (run_len[i] < run_len[best])
						best = i;
				len = run_len[best];
				r.cpu = CPU_W'(best);
				r.tid = it.tid;
				if (len >= MAX_TASKS) begin
					r.status = STATUS_FULL;
				end else begin
					list_tid[best][len] = it.tid;
					list_ready[best][len] = it.rdy;
					run_len[best] = LEN_BITS'(len + 1);
					r.slot = SLOT_W'(len);
				end
			end
			FUNC_READY: begin
				if (it.cpu < act) begin
					r.slot = it.slot;
					if (it.slot < run_len[it.cpu]) begin
						list_ready[it.cpu][it.slot] = it.rdy;
						r.tid = list_tid[it.cpu][it.slot];
					end
				end
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic sched_item_t random_item();
		sched_item_t it;
		int pick;
		pick = $urandom_range(99);
		if (pick < 50)
			it.func = FUNC_TICK;
		else if (pick < 65)
			it.func = FUNC_PUSH;
		else if (pick < 95)
			it.func = FUNC_READY;
		else
			it.func = FUNC_UNUSED;
		it.cpu = CPU_W'($urandom_range(NUM_CPUS - 1));
		it.slot = SLOT_W'(($urandom_range(99) < 70) ? $urandom_range(7) :
			$urandom_range(MAX_TASKS - 1));
		it.tid = TASK_W'($urandom);
		it.rdy = $urandom_range(99) < 75;
		return it;
	endfunction

	task automatic add_item(input logic [FUNC_BITS-1:0] func, input int cpu, input int slot,
			input logic [TASK_W-1:0] tid, input logic rdy);
		sched_item_t it;
		it.func = func;
		it.cpu = CPU_W'(cpu);
		it.slot = SLOT_W'(slot);
		it.tid = tid;
		it.rdy = rdy;
		queued_items.push_back(it);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s at %0t: got %0h, want %0h", what, $realtime, got, want);
		fail_count++;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (queued_items.size() != 0 || req_if.valid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_QUANTUM)
			cfg_quantum = data[QUANT_BITS-1:0];
		else if (addr == ADDR_ACTIVE)
			cfg_active = data[ACT_BITS-1:0];
	endtask

	// driver: offers queued items, predicts each one on transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else begin
			if (req_if.valid && req_if.ready)
				expected_results.push_back(schedule_item({req_if.func, req_if.cpu_index,
					req_if.slot_index, req_if.task_id, req_if.ready_in}));
			if (!req_if.valid || req_if.ready) begin
				if (queued_items.size() != 0 && !take_break()) begin
					req_if.func <= queued_items[0].func;
					req_if.cpu_index <= queued_items[0].cpu;
					req_if.slot_index <= queued_items[0].slot;
					req_if.task_id <= queued_items[0].tid;
					req_if.ready_in <= queued_items[0].rdy;
					req_if.valid <= 1'b1;
					void'(queued_items.pop_front());
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transfer against the oldest prediction
	always @(posedge clk) begin
		sched_result_t want;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", rsp_if.task_out, 0);
				end else begin
					want = expected_results.pop_front();
					if (rsp_if.switched !== want.switched)
						report_mismatch("switched", rsp_if.switched, want.switched);
					if (rsp_if.cpu_out !== want.cpu)
						report_mismatch("cpu_out", rsp_if.cpu_out, want.cpu);
					if (rsp_if.slot_out !== want.slot)
						report_mismatch("slot_out", rsp_if.slot_out, want.slot);
					if (rsp_if.task_out !== want.tid)
						report_mismatch("task_out", rsp_if.task_out, want.tid);
					if (rsp_if.status !== want.status)
						report_mismatch("status", rsp_if.status, want.status);
				end
			end
			rsp_if.ready <= !take_break();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [QUANT_BITS-1:0] phase_quantum [RAND_PHASES];
		logic [ACT_BITS-1:0]   phase_active  [RAND_PHASES];
		phase_quantum = '{16'd0, 16'd3, 16'hFFFF, 16'd1, 16'd20, 16'd2, 16'd7};
		phase_active  = '{3'd4, 3'd2, 3'd3, 3'd7, 3'd0, 3'd1, 3'd4};
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_if.valid = 1'b0;
		req_if.func = FUNC_TICK;
		req_if.cpu_index = '0;
		req_if.slot_index = '0;
		req_if.task_id = '0;
		req_if.ready_in = 1'b0;
		rsp_if.ready = 1'b0;
		fail_count = 0;
		stall_pct = 21;
		quiet_cycles = 0;
		cfg_quantum = QUANTUM_RESET;
		cfg_active = ACT_RESET;
		for (int c = 0; c < NUM_CPUS; c++) begin
			for (int s = 0; s < MAX_TASKS; s++) begin
				list_tid[c][s] = '0;
				list_ready[c][s] = 1'b0;
			end
			list_ready[c][0] = MARK_READY;
			run_len[c] = LEN_BITS'(1);
			cur_slot[c] = '0;
			tick_cnt[c] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: unused code, plain ticks, slot past the list end, pushes
		add_item(FUNC_UNUSED, 3, 15, 16'hFFFF, 1'b1);
		for (int c = 0; c < NUM_CPUS; c++)
			add_item(FUNC_TICK, c, 0, 16'h0000, 1'b0);
		add_item(FUNC_READY, 2, 15, 16'h0000, 1'b1);
		add_item(FUNC_READY, 3, 0, 16'h0000, 1'b0);
		add_item(FUNC_PUSH, 0, 0, 16'hFFFF, 1'b1);
		add_item(FUNC_PUSH, 3, 15, 16'h0000, 1'b0);
		add_item(FUNC_READY, 3, 0, 16'h0000, 1'b1);
		wait_drained();

		// one processor, zero quantum: inactive processors, switching, nothing ready
		write_reg(ADDR_QUANTUM, 32'd0);
		write_reg(ADDR_ACTIVE, 32'd1);
		add_item(FUNC_TICK, 2, 0, 16'h0000, 1'b0);
		add_item(FUNC_READY, 3, 0, 16'h0000, 1'b1);
		add_item(FUNC_READY, 0, 0, 16'h0000, 1'b0);
		add_item(FUNC_PUSH, 1, 0, 16'h1234, 1'b0);
		repeat (3) add_item(FUNC_TICK, 0, 0, 16'h0000, 1'b0);
		add_item(FUNC_READY, 0, 1, 16'h0000, 1'b0);
		repeat (2) add_item(FUNC_TICK, 0, 0, 16'h0000, 1'b0);
		add_item(FUNC_READY, 0, 1, 16'h0000, 1'b1);
		wait_drained();

		for (int p = 0; p < RAND_PHASES; p++) begin
			write_reg(ADDR_QUANTUM, {16'h0000, phase_quantum[p]});
			write_reg(ADDR_ACTIVE, {29'd0, phase_active[p]});
			// a whole phase at full throughput on both sides
			stall_pct = (p == 3) ? 0 : 21;
			for (int n = 0; n < PHASE_ITEMS; n++)
				queued_items.push_back(random_item());
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results left over", 0, expected_results.size());
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> files.f
hdl/qrrts_pkg.sv
hdl/qrrts_if.sv
hdl/qrrts_ctrl.sv
hdl/qrrts_dp.sv
hdl/quantum_round_robin_task_scheduler.sv
tb/tb_top.sv
